FILE: rtl/ptvs_pkg.sv
// Package for the page table with victim select.
// Holds payload word types, request, status and policy codes, and the control state type.
// No dependencies.
package ptvs_pkg;

  localparam logic [1:0] REQ_MAP     = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_WRITE   = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [1:0] POL_LFU  = 2'd0;
  localparam logic [1:0] POL_SC   = 2'd1;
  localparam logic [1:0] POL_MFU  = 2'd2;
  // Spare encoding; behaves as least frequently used.
  localparam logic [1:0] POL_RSVD = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FAULT  = 3'd1;
  localparam logic [2:0] ST_NOMAP  = 3'd2;
  localparam logic [2:0] ST_NOVICT = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pid;
    logic [31:0] vaddr;
    logic [11:0] frame;
    logic        resident;
  } ptvs_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] paddr;
    logic [19:0] victim_vpage;
    logic [31:0] fault_total;
  } ptvs_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_VSCAN,
    S_DEC,
    S_WVICT,
    S_WPAGE,
    S_RESP
  } ptvs_state_t;

endpackage

FILE: rtl/ptvs_ram.sv
// Single-port-write, single-port-read entry memory with registered read data.
// No dependencies.
module ptvs_ram #(
  parameter int W = 89,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/page_table_with_victim_select_top.sv
// Top level of the page table with victim select.
// Depends on ptvs_pkg and ptvs_ram.
//
// Usage: one input word per request (map, read, write) on in_valid/in_stall/in_data,
// one result word per request on out_valid/out_stall/out_data. The policy register
// is read at address 0 of the APB port; every APB write sets it, whatever its paddr.
// Write it only while the block is idle; the block itself does not enforce this.
// Entries live in one synchronous memory; every pass over it reads one entry a cycle.
// Steps: a map or an unknown request goes straight to the response state. A read
// or write first scans for its page and stops at a match; a hit then writes the page
// back. A fault adds a victim scan, for second chance a decrement pass, then writes
// the victim and the page if a victim is found.
// One request is handled at a time; in_stall is high from acceptance until the
// result is loaded into the output register, so the next word is taken while a
// result still waits there. If the receiver stalls, the result holds and a
// finished next result waits in the block until the register frees.
// Reset (synchronous, rst_n low) empties the table and clears time, fault count
// and policy; no clearing pass is needed, the fill level marks valid entries.
module page_table_with_victim_select_top
  import ptvs_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int PAGE_BITS  = 12,
  parameter int FRAME_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ptvs_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ptvs_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam int PW = FRAME_BITS + PAGE_BITS;
  localparam logic [CW-1:0] FULL_LEVEL = CW'(ENTRIES);

  typedef struct packed {
    logic [7:0]            pid;
    logic [19:0]           vpage;
    logic [FRAME_BITS-1:0] frame;
    logic                  resident;
    logic [15:0]           cnt;
    logic [31:0]           arr;
  } ent_t;

  localparam int EW = $bits(ent_t);

  ptvs_state_t state_r, state_nxt;
  logic [1:0]    policy_r;
  logic [31:0]   time_r, time_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [31:0]   fault_r, fault_nxt;
  ptvs_in_t      req_r;
  logic [CW-1:0] issue_r, issue_nxt;
  logic          rv_r, rv_nxt;
  logic [IW-1:0] ridx_r, ridx_nxt;
  ent_t          pg_r, pg_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  ent_t          a_r, a_nxt;
  logic [IW-1:0] aidx_r, aidx_nxt;
  logic          afound_r, afound_nxt;
  ent_t          b_r, b_nxt;
  logic [IW-1:0] bidx_r, bidx_nxt;
  logic          bfound_r, bfound_nxt;
  ent_t          v_r, v_nxt;
  logic [IW-1:0] vidx_r, vidx_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [23:0]   paddr_r, paddr_nxt;
  logic [19:0]   victim_r, victim_nxt;
  logic          out_valid_r;
  ptvs_out_t     out_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  ent_t          wdata, rdata;
  logic [EW-1:0] rdata_raw;

  logic          accept, issue_ok, scan_end, match, cand, slot_free;
  logic [19:0]   vpage_r;
  logic [PAGE_BITS-1:0] off_r;
  logic [19:0]   frame_ext;
  logic [16:0]   cnt_sum;
  logic [15:0]   cnt_new;
  logic [PW+23:0] paddr_wide;

  ptvs_ram #(.W(EW), .D(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );
  assign rdata = ent_t'(rdata_raw);

  assign pready    = 1'b1;
  assign prdata    = (paddr == 2'd0) ? {30'd0, policy_r} : 32'd0;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || !out_stall;

  assign vpage_r   = 20'(req_r.vaddr >> PAGE_BITS);
  assign off_r     = req_r.vaddr[PAGE_BITS-1:0];
  assign frame_ext = 20'(in_data.frame);
  assign issue_ok  = issue_r < fill_r;
  assign scan_end  = !rv_r && !issue_ok;
  assign raddr     = issue_r[IW-1:0];
  assign match     = rv_r && rdata.pid == req_r.pid && rdata.vpage == vpage_r;
  assign cand      = rv_r && rdata.resident &&
                     (policy_r == POL_SC || rdata.pid == req_r.pid);

  // Read adds 3 on an even count and 2 on an odd one; write adds 2.
  assign cnt_sum = {1'b0, pg_r.cnt} +
                   ((req_r.req_type == REQ_READ && !pg_r.cnt[0]) ? 17'd3 : 17'd2);
  assign cnt_new = cnt_sum[16] ? COUNT_MAX : cnt_sum[15:0];
  assign paddr_wide = {24'd0, pg_r.frame, off_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_READ || in_data.req_type == REQ_WRITE) begin
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_LOOK: begin
        if (match) begin
          state_nxt = rdata.resident ? S_WPAGE : S_VSCAN;
        end else if (scan_end) begin
          state_nxt = S_RESP;
        end
      end
      S_VSCAN: begin
        if (scan_end) begin
          if (policy_r == POL_SC) begin
            state_nxt = bfound_r ? S_DEC : S_RESP;
          end else begin
            state_nxt = afound_r ? S_WVICT : S_RESP;
          end
        end
      end
      S_DEC: begin
        if (scan_end) begin
          state_nxt = S_WVICT;
        end
      end
      S_WVICT: state_nxt = S_WPAGE;
      S_WPAGE: state_nxt = S_RESP;
      S_RESP: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    time_nxt   = time_r;
    fill_nxt   = fill_r;
    fault_nxt  = fault_r;
    issue_nxt  = '0;
    rv_nxt     = 1'b0;
    ridx_nxt   = ridx_r;
    pg_nxt     = pg_r;
    pidx_nxt   = pidx_r;
    a_nxt      = a_r;
    aidx_nxt   = aidx_r;
    afound_nxt = afound_r;
    b_nxt      = b_r;
    bidx_nxt   = bidx_r;
    bfound_nxt = bfound_r;
    v_nxt      = v_r;
    vidx_nxt   = vidx_r;
    status_nxt = status_r;
    paddr_nxt  = paddr_r;
    victim_nxt = victim_r;
    we         = 1'b0;
    waddr      = fill_r[IW-1:0];
    wdata      = pg_r;

    if (state_r == S_LOOK || state_r == S_VSCAN || state_r == S_DEC) begin
      if (issue_ok) begin
        issue_nxt = issue_r + CW'(1);
        rv_nxt    = 1'b1;
        ridx_nxt  = issue_r[IW-1:0];
      end else begin
        issue_nxt = issue_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        status_nxt = ST_NOMAP;
        paddr_nxt  = '0;
        victim_nxt = '0;
        afound_nxt = 1'b0;
        bfound_nxt = 1'b0;
        if (accept) begin
          if (in_data.req_type == REQ_MAP) begin
            if (fill_r == FULL_LEVEL) begin
              status_nxt = ST_FULL;
            end else begin
              we             = 1'b1;
              wdata.pid      = in_data.pid;
              wdata.vpage    = 20'(in_data.vaddr >> PAGE_BITS);
              wdata.frame    = frame_ext[FRAME_BITS-1:0];
              wdata.resident = in_data.resident;
              wdata.cnt      = '0;
              wdata.arr      = time_r;
              time_nxt       = (time_r == '1) ? time_r : time_r + 32'd1;
              fill_nxt       = fill_r + CW'(1);
              status_nxt     = ST_OK;
            end
          end else if (in_data.req_type == REQ_READ || in_data.req_type == REQ_WRITE) begin
            time_nxt = (time_r == '1) ? time_r : time_r + 32'd1;
          end
        end
      end
      S_LOOK: begin
        if (match) begin
          issue_nxt = '0;
          rv_nxt    = 1'b0;
          pg_nxt    = rdata;
          pidx_nxt  = ridx_r;
          status_nxt = ST_OK;
          if (!rdata.resident) begin
            fault_nxt = (fault_r == '1) ? fault_r : fault_r + 32'd1;
          end
        end else if (scan_end) begin
          issue_nxt = '0;
        end
      end
      S_VSCAN: begin
        if (cand) begin
          if (policy_r == POL_SC) begin
            if (!bfound_r || rdata.arr < b_r.arr) begin
              b_nxt      = rdata;
              bidx_nxt   = ridx_r;
              bfound_nxt = 1'b1;
            end
            if (!rdata.cnt[0] && (!afound_r || rdata.arr < a_r.arr)) begin
              a_nxt      = rdata;
              aidx_nxt   = ridx_r;
              afound_nxt = 1'b1;
            end
          end else if (!afound_r ||
                       (policy_r == POL_MFU ? rdata.cnt > a_r.cnt : rdata.cnt < a_r.cnt)) begin
            a_nxt      = rdata;
            aidx_nxt   = ridx_r;
            afound_nxt = 1'b1;
          end
        end
        if (scan_end) begin
          issue_nxt = '0;
          if (afound_r) begin
            v_nxt    = a_r;
            vidx_nxt = aidx_r;
          end else begin
            v_nxt    = b_r;
            vidx_nxt = bidx_r;
          end
          if (!(policy_r == POL_SC ? bfound_r : afound_r)) begin
            status_nxt = ST_NOVICT;
          end
        end
      end
      S_DEC: begin
        // Drop odd pages' reference marks ahead of the even pick, or all if none.
        if (cand && rdata.cnt[0] &&
            (!afound_r || rdata.arr < a_r.arr ||
             (rdata.arr == a_r.arr && ridx_r < aidx_r))) begin
          we        = 1'b1;
          waddr     = ridx_r;
          wdata     = rdata;
          wdata.cnt = rdata.cnt - 16'd1;
        end
      end
      S_WVICT: begin
        we             = 1'b1;
        waddr          = vidx_r;
        wdata          = v_r;
        wdata.resident = 1'b0;
        wdata.cnt      = '0;
        pg_nxt.frame    = v_r.frame;
        pg_nxt.cnt      = '0;
        pg_nxt.arr      = time_r;
        pg_nxt.resident = 1'b1;
        time_nxt   = (time_r == '1) ? time_r : time_r + 32'd1;
        victim_nxt = v_r.vpage;
        status_nxt = ST_FAULT;
      end
      S_WPAGE: begin
        we        = 1'b1;
        waddr     = pidx_r;
        wdata     = pg_r;
        wdata.cnt = cnt_new;
        paddr_nxt = paddr_wide[23:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_LFU;
      time_r      <= '0;
      fill_r      <= '0;
      fault_r     <= '0;
      issue_r     <= '0;
      rv_r        <= 1'b0;
      afound_r    <= 1'b0;
      bfound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      fill_r   <= fill_nxt;
      fault_r  <= fault_nxt;
      issue_r  <= issue_nxt;
      rv_r     <= rv_nxt;
      afound_r <= afound_nxt;
      bfound_r <= bfound_nxt;
      if (psel && penable && pwrite && pready) begin
        policy_r <= pwdata[1:0];
      end
      if (state_r == S_RESP && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    ridx_r   <= ridx_nxt;
    pg_r     <= pg_nxt;
    pidx_r   <= pidx_nxt;
    a_r      <= a_nxt;
    aidx_r   <= aidx_nxt;
    b_r      <= b_nxt;
    bidx_r   <= bidx_nxt;
    v_r      <= v_nxt;
    vidx_r   <= vidx_nxt;
    status_r <= status_nxt;
    paddr_r  <= paddr_nxt;
    victim_r <= victim_nxt;
    if (state_r == S_RESP && slot_free) begin
      out_r.status       <= status_r;
      out_r.paddr        <= paddr_r;
      out_r.victim_vpage <= victim_r;
      out_r.fault_total  <= fault_r;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_LEVEL)
    else $error("fill level beyond table depth");

  a_fault_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fault_r >= $past(fault_r))
    else $error("fault count went down");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result word raised outside response state");

  a_victim_not_page: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WVICT |-> vidx_r != pidx_r)
    else $error("victim is the faulting page");

endmodule

FILE: tb/sv/page_table_with_victim_select_top_test.sv
// Self-checking bench for the page table with victim select: drives map, read, write and
// unknown words, predicts every result word in a scoreboard class, checks field by field.
// Depends on ptvs_pkg and page_table_with_victim_select_top.
`timescale 1ns / 100ps

module page_table_with_victim_select_top_test;
  import ptvs_pkg::*;

  localparam int NENT = 64;
  localparam int LIMIT = 3000000;

  class page_scoreboard;
    logic        e_valid [NENT];
    logic [7:0]  e_pid [NENT];
    logic [19:0] e_vpage [NENT];
    logic [11:0] e_frame [NENT];
    logic        e_res [NENT];
    logic [15:0] e_count [NENT];
    logic [31:0] e_arr [NENT];
    logic [31:0] clock_now;
    int          fill;
    logic [31:0] faults;
    logic [1:0]  policy;
    ptvs_out_t   pending[$];
    int          errors;
    int          checked;

    function void clear();
      for (int i = 0; i < NENT; i++) e_valid[i] = 0;
      clock_now = 0;
      fill = 0;
      faults = 0;
      policy = POL_LFU;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function logic [15:0] add_sat(logic [15:0] c, int a);
      int s;
      s = c + a;
      return (s > 16'hFFFF) ? 16'hFFFF : s[15:0];
    endfunction

    function bit older(int a, int b);
      if (e_arr[a] != e_arr[b]) return e_arr[a] < e_arr[b];
      return a < b;
    endfunction

    function int pick_count(logic [7:0] pid, bit most);
      int best;
      best = -1;
      for (int i = 0; i < NENT; i++) begin
        if (!(e_valid[i] && e_res[i]) || e_pid[i] != pid) continue;
        if (best < 0 || (most ? e_count[i] > e_count[best] : e_count[i] < e_count[best]))
          best = i;
      end
      return best;
    endfunction

    function int pick_second_chance();
      int first, even;
      first = -1;
      even = -1;
      for (int i = 0; i < NENT; i++) begin
        if (!(e_valid[i] && e_res[i])) continue;
        if (first < 0 || older(i, first)) first = i;
        if (!e_count[i][0] && (even < 0 || older(i, even))) even = i;
      end
      if (first < 0) return -1;
      // strip the reference mark from odd pages ahead of the even pick, or all if none
      for (int i = 0; i < NENT; i++) begin
        if (!(e_valid[i] && e_res[i]) || !e_count[i][0]) continue;
        if (even < 0 || older(i, even)) e_count[i] = e_count[i] - 1;
      end
      return (even >= 0) ? even : first;
    endfunction

    function void note_word(ptvs_in_t w);
      ptvs_out_t r;
      logic [19:0] vp;
      int e, v;
      r = '0;
      r.status = ST_NOMAP;
      vp = w.vaddr[31:12];
      if (w.req_type == REQ_MAP) begin
        if (fill >= NENT) r.status = ST_FULL;
        else begin
          e = fill;
          e_valid[e] = 1; e_pid[e] = w.pid; e_vpage[e] = vp; e_frame[e] = w.frame;
          e_res[e] = w.resident; e_count[e] = 0; e_arr[e] = clock_now;
          clock_now = bump(clock_now);
          fill++;
          r.status = ST_OK;
        end
      end else if (w.req_type == REQ_READ || w.req_type == REQ_WRITE) begin
        clock_now = bump(clock_now);
        e = -1;
        for (int i = NENT - 1; i >= 0; i--)
          if (e_valid[i] && e_pid[i] == w.pid && e_vpage[i] == vp) e = i;
        if (e >= 0) begin
          r.status = ST_OK;
          if (!e_res[e]) begin
            faults = bump(faults);
            if (policy == POL_SC) v = pick_second_chance();
            else v = pick_count(w.pid, policy == POL_MFU);
            if (v < 0) r.status = ST_NOVICT;
            else begin
              e_res[v] = 0; e_count[v] = 0;
              e_frame[e] = e_frame[v]; e_count[e] = 0; e_arr[e] = clock_now;
              clock_now = bump(clock_now);
              e_res[e] = 1;
              r.victim_vpage = e_vpage[v];
              r.status = ST_FAULT;
            end
          end
          if (r.status != ST_NOVICT) begin
            r.paddr = {e_frame[e], w.vaddr[11:0]};
            if (w.req_type == REQ_READ) e_count[e] = add_sat(e_count[e], e_count[e][0] ? 2 : 3);
            else e_count[e] = add_sat(e_count[e], 2);
          end
        end
      end
      r.fault_total = faults;
      pending = {pending, r};
    endfunction

    function void check_word(ptvs_out_t got);
      ptvs_out_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h (expected none)", $time, got);
        errors++;
        return;
      end
      x = pending.pop_front();
      checked++;
      if (got.status !== x.status) begin
        $display("%0t: status expected %0d actual %0d", $time, x.status, got.status); errors++;
      end
      if (got.paddr !== x.paddr) begin
        $display("%0t: paddr expected %h actual %h", $time, x.paddr, got.paddr); errors++;
      end
      if (got.victim_vpage !== x.victim_vpage) begin
        $display("%0t: victim_vpage expected %h actual %h", $time, x.victim_vpage,
                 got.victim_vpage);
        errors++;
      end
      if (got.fault_total !== x.fault_total) begin
        $display("%0t: fault_total expected %0d actual %0d", $time, x.fault_total,
                 got.fault_total);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  ptvs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  ptvs_out_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  page_scoreboard board;
  int cycles = 0;
  int hold_off = 0;
  bit quiet = 0;
  int sent = 0;
  logic [7:0] pids [4];

  page_table_with_victim_select_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, long hold-offs on request
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= !quiet && ($urandom_range(99) < 6);
  end

  // hold valid after acceptance; the next word, an idle cycle or a drain drops it
  task automatic send(ptvs_in_t w);
    if (!quiet) begin
      while ($urandom_range(99) < 6) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    // the last result can leave before the block settles
    repeat (250) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    drain();
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 2'd0; pwdata <= {30'd0, p};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.policy = p;
  endtask

  function automatic ptvs_in_t make(logic [1:0] t, logic [7:0] pid, logic [31:0] va,
                                    logic [11:0] fr, logic res);
    ptvs_in_t w;
    w.req_type = t; w.pid = pid; w.vaddr = va; w.frame = fr; w.resident = res;
    return w;
  endfunction

  // mostly well-formed: maps mixed with accesses on a small page set
  task automatic random_phase(int n);
    logic [1:0] t;
    for (int i = 0; i < n; i++) begin
      t = ($urandom_range(99) < 12) ? REQ_MAP : ($urandom_range(1) ? REQ_READ : REQ_WRITE);
      if ($urandom_range(99) < 3) t = REQ_UNKNOWN;
      if (i == n / 2 && hold_off == 0) hold_off = 400;
      send(make(t, ($urandom_range(99) < 5) ? 8'($urandom) : pids[$urandom_range(3)],
                {20'(12'($urandom_range(15))) ^
                 (($urandom_range(9) == 0) ? (20'($urandom) << 4) : 20'd0),
                 12'($urandom)}, 12'($urandom), $urandom_range(99) < 40));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    for (int i = 0; i < 4; i++) pids[i] = 8'($urandom);
    pids[0] = 8'hFF;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: every request type, extremes, no victim, duplicate, unknown type
    send(make(REQ_READ, 8'h00, 32'h0, 12'h0, 0));
    send(make(REQ_MAP, 8'hFF, 32'hFFFF_FFFF, 12'hFFF, 1));
    send(make(REQ_MAP, 8'hFF, 32'h0000_1000, 12'h000, 0));
    send(make(REQ_MAP, 8'hFF, 32'h0000_1ABC, 12'h055, 1));
    send(make(REQ_MAP, 8'h00, 32'h0000_2000, 12'hAAA, 0));
    send(make(REQ_READ, 8'hFF, 32'hFFFF_FFFF, 12'h0, 0));
    send(make(REQ_WRITE, 8'hFF, 32'hFFFF_F000, 12'h0, 0));
    send(make(REQ_READ, 8'hFF, 32'h0000_1234, 12'h0, 0));
    send(make(REQ_READ, 8'h00, 32'h0000_2FFF, 12'h0, 0));
    send(make(REQ_UNKNOWN, 8'h5A, 32'hA5A5_A5A5, 12'h5A5, 1));
    send(make(REQ_WRITE, 8'h00, 32'h0000_2001, 12'h0, 1));
    set_policy(POL_MFU);
    send(make(REQ_MAP, 8'hFF, 32'h0000_3000, 12'h123, 0));
    send(make(REQ_READ, 8'hFF, 32'h0000_3FFF, 12'h0, 0));
    set_policy(POL_SC);
    send(make(REQ_MAP, 8'h00, 32'h0000_4000, 12'h0, 0));
    send(make(REQ_READ, 8'h00, 32'h0000_4001, 12'h0, 0));
    send(make(REQ_WRITE, 8'hFF, 32'h0000_1000, 12'h0, 0));

    // fill the table, then a map on a full table
    while (board.fill < NENT)
      send(make(REQ_MAP, pids[$urandom_range(3)],
                {8'd0, 12'($urandom_range(15)), 12'($urandom)},
                12'($urandom), $urandom_range(1)));
    send(make(REQ_MAP, 8'h01, 32'h0, 12'h0, 1));

    random_phase(400);
    set_policy(POL_LFU);
    random_phase(400);
    // sender waits for every result before resuming
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    set_policy(POL_RSVD);
    random_phase(100);
    set_policy(POL_MFU);
    quiet = 1;
    random_phase(300);
    quiet = 0;
    set_policy(POL_SC);
    random_phase(420);

    drain();
    $display("Covered %0d words, %0d results checked, all policies and a full table.",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: page_table_with_victim_select_top.f
rtl/ptvs_pkg.sv
rtl/ptvs_ram.sv
rtl/page_table_with_victim_select_top.sv
tb/sv/page_table_with_victim_select_top_test.sv
